/* rtl/double_ended_queue_with_delete_macros.svh */
`ifndef DOUBLE_ENDED_QUEUE_WITH_DELETE_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_WITH_DELETE_MACROS_SVH

// holds at every edge outside reset
`define DEQD_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// cond at one edge implies expr at the next
`define DEQD_NEXT(lbl, cond, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) else $error(msg);

`endif

/* rtl/deqd_pkg.sv */
`timescale 1ns / 1ps

package deqd_pkg;

  localparam int DEPTH      = 64;
  localparam int DATA_WIDTH = 32;
  localparam int IDX_W      = $clog2(DEPTH);
  localparam int CNT_W      = $clog2(DEPTH + 1);

  localparam logic [2:0] OP_PUSH_BACK  = 3'd0;
  localparam logic [2:0] OP_POP_BACK   = 3'd1;
  localparam logic [2:0] OP_PUSH_FRONT = 3'd2;
  localparam logic [2:0] OP_POP_FRONT  = 3'd3;
  localparam logic [2:0] OP_DELETE     = 3'd4;
  localparam logic [2:0] OP_COUNT      = 3'd5;

  typedef struct packed {
    logic [2:0]            operation;
    logic [DATA_WIDTH-1:0] value;
  } req_t;

  typedef struct packed {
    logic [DATA_WIDTH-1:0] data_out;
    logic [CNT_W-1:0]      item_total;
    logic                  was_empty;
    logic                  dropped_full;
    logic                  match_found;
  } rsp_t;

endpackage

/* rtl/double_ended_queue_with_delete.sv */
`timescale 1ns / 1ps

// bounded double-ended queue with delete-by-value, held in one ring memory
// request channel (req_valid / req_stall / req): one beat carries an
// operation code and a value; response channel (rsp_valid / rsp_stall / rsp):
// one beat per request with popped word, count after the operation and flags
// what each request does between accept and the response register:
//   push back, push front: one memory write, no read; count: no memory access
//   pop back, pop front: synchronous memory read, then the response
//   delete: walk from the front to the match, then shift the tail down,
//   one entry per cycle through the single read port
// one request is in flight at a time; req_stall is high while a request is
// at work and while a finished response waits under rsp_stall, and drops in
// the cycle the response beat is taken
// reset clears the front pointer, the count and the response valid; the ring
// memory itself is not cleared and needs no sweep, since only written slots
// are ever read
// while rsp_stall is high the response register holds its beat unchanged

module double_ended_queue_with_delete (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  deqd_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output deqd_pkg::rsp_t rsp
);

  localparam int IDX_W = deqd_pkg::IDX_W;
  localparam int CNT_W = deqd_pkg::CNT_W;
  localparam int DW    = deqd_pkg::DATA_WIDTH;

  typedef enum logic [1:0] {S_IDLE, S_POP, S_SEARCH, S_SHIFT} state_t;

  state_t           state;
  logic [IDX_W-1:0] front;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] idx;
  logic [DW-1:0]    key;

  logic [DW-1:0]    mem [deqd_pkg::DEPTH];
  logic [DW-1:0]    rd_data;
  logic [IDX_W-1:0] rd_addr;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic [DW-1:0]    wr_data;

  logic             accept;
  logic             is_full;
  logic             is_empty;
  logic [CNT_W:0]   idx1;
  logic [CNT_W:0]   idx2;
  logic             more1;
  logic             more2;
  logic [IDX_W-1:0] front_dec;
  logic [IDX_W-1:0] front_inc;
  logic [CNT_W-1:0] count_dec;

  function automatic logic [IDX_W-1:0] slot(input logic [IDX_W-1:0] front_i,
                                            input logic [IDX_W-1:0] off);
    logic [IDX_W:0] sum;
    logic [IDX_W:0] red;
    sum = {1'b0, front_i} + {1'b0, off};
    red = sum - (IDX_W+1)'(deqd_pkg::DEPTH);
    return (sum >= (IDX_W+1)'(deqd_pkg::DEPTH)) ? red[IDX_W-1:0] : sum[IDX_W-1:0];
  endfunction

  assign req_stall = (state != S_IDLE) || (rsp_valid && rsp_stall);
  assign accept    = req_valid && !req_stall;
  assign is_full   = (count == CNT_W'(deqd_pkg::DEPTH));
  assign is_empty  = (count == '0);
  assign idx1      = {1'b0, idx} + (CNT_W+1)'(1);
  assign idx2      = {1'b0, idx} + (CNT_W+1)'(2);
  assign more1     = idx1 < {1'b0, count};
  assign more2     = idx2 < {1'b0, count};
  assign front_dec = (front == '0) ? IDX_W'(deqd_pkg::DEPTH - 1) : front - IDX_W'(1);
  assign front_inc = slot(front, IDX_W'(1));
  assign count_dec = count - CNT_W'(1);

  always_comb begin
    rd_addr = front;
    wr_en   = 1'b0;
    wr_addr = front;
    wr_data = req.value;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (req.operation)
            deqd_pkg::OP_PUSH_BACK: begin
              wr_en   = !is_full;
              wr_addr = slot(front, count[IDX_W-1:0]);
            end
            deqd_pkg::OP_PUSH_FRONT: begin
              wr_en   = !is_full;
              wr_addr = front_dec;
            end
            deqd_pkg::OP_POP_BACK: rd_addr = slot(front, count_dec[IDX_W-1:0]);
            default: rd_addr = front;
          endcase
        end
      end
      S_POP: rd_addr = front;
      S_SEARCH: rd_addr = slot(front, idx1[IDX_W-1:0]);
      S_SHIFT: begin
        rd_addr = slot(front, idx2[IDX_W-1:0]);
        wr_en   = 1'b1;
        wr_addr = slot(front, idx[IDX_W-1:0]);
        wr_data = rd_data;
      end
      default: rd_addr = front;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      front     <= '0;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            key              <= req.value;
            rsp.data_out     <= '0;
            rsp.item_total   <= count;
            rsp.was_empty    <= 1'b0;
            rsp.dropped_full <= 1'b0;
            rsp.match_found  <= 1'b0;
            unique case (req.operation) inside
              deqd_pkg::OP_PUSH_BACK, deqd_pkg::OP_PUSH_FRONT: begin
                rsp_valid <= 1'b1;
                if (is_full) begin
                  rsp.dropped_full <= 1'b1;
                end else begin
                  count          <= count + CNT_W'(1);
                  rsp.item_total <= count + CNT_W'(1);
                  if (req.operation == deqd_pkg::OP_PUSH_FRONT) begin
                    front <= front_dec;
                  end
                end
              end
              deqd_pkg::OP_POP_BACK, deqd_pkg::OP_POP_FRONT: begin
                if (is_empty) begin
                  rsp.was_empty <= 1'b1;
                  rsp_valid     <= 1'b1;
                end else begin
                  count          <= count_dec;
                  rsp.item_total <= count_dec;
                  if (req.operation == deqd_pkg::OP_POP_FRONT) begin
                    front <= front_inc;
                  end
                  state <= S_POP;
                end
              end
              deqd_pkg::OP_DELETE: begin
                if (is_empty) begin
                  rsp_valid <= 1'b1;
                end else begin
                  idx   <= '0;
                  state <= S_SEARCH;
                end
              end
              default: rsp_valid <= 1'b1;
            endcase
          end
        end
        S_POP: begin
          rsp.data_out <= rd_data;
          rsp_valid    <= 1'b1;
          state        <= S_IDLE;
        end
        S_SEARCH: begin
          if (rd_data == key) begin
            if (more1) begin
              state <= S_SHIFT;
            end else begin
              count           <= count_dec;
              rsp.item_total  <= count_dec;
              rsp.match_found <= 1'b1;
              rsp_valid       <= 1'b1;
              state           <= S_IDLE;
            end
          end else if (more1) begin
            idx <= idx1[CNT_W-1:0];
          end else begin
            rsp_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        S_SHIFT: begin
          if (more2) begin
            idx <= idx1[CNT_W-1:0];
          end else begin
            count           <= count_dec;
            rsp.item_total  <= count_dec;
            rsp.match_found <= 1'b1;
            rsp_valid       <= 1'b1;
            state           <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* rtl/deqd_checker.sv */
`timescale 1ns / 1ps
`include "double_ended_queue_with_delete_macros.svh"

module deqd_assert (
  input logic           clk,
  input logic           rst,
  input logic           req_valid,
  input logic           req_stall,
  input deqd_pkg::req_t req,
  input logic           rsp_valid,
  input logic           rsp_stall,
  input deqd_pkg::rsp_t rsp
);

  logic [2:0] flags;

  assign flags = {rsp.was_empty, rsp.dropped_full, rsp.match_found};

  // a stalled response beat holds
  `DEQD_NEXT(rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp), "response changed under stall")
  // no new request while a response is blocked
  `DEQD_ALWAYS(no_accept_blocked, !(rsp_valid && rsp_stall) || req_stall, "request taken while response blocked")
  `DEQD_ALWAYS(total_bound, !rsp_valid || (rsp.item_total <= deqd_pkg::CNT_W'(deqd_pkg::DEPTH)), "count above depth")
  `DEQD_ALWAYS(empty_pop, !(rsp_valid && rsp.was_empty) || (rsp.data_out == '0 && rsp.item_total == '0), "empty pop with data or count")
  `DEQD_ALWAYS(one_flag, !rsp_valid || $onehot0(flags), "more than one status flag")

endmodule

bind double_ended_queue_with_delete deqd_assert u_deqd_assert (.*);
